FILE: rtl/smid_pkg.sv
// Package for the sorted multiset insert/delete block.
// Holds store sizing constants, op codes and field conversion helpers.
`default_nettype none

package smid_pkg;

    localparam int CAPACITY = 32;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 6;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    function automatic logic [POS_W-1:0] pos_of(input logic [CNT_W-1:0] k);
        logic [CNT_W+POS_W-1:0] tmp;
        tmp = {{POS_W{1'b0}}, k};
        return tmp[POS_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] count_of(input logic [CNT_W-1:0] c);
        logic [CNT_W+COUNT_W-1:0] tmp;
        tmp = {{COUNT_W{1'b0}}, c};
        return tmp[COUNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/smid_in_if.sv
// Command channel: one word carries an op and a signed value.
// Depends on smid_pkg for the value width.
`default_nettype none

interface smid_in_if
    import smid_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic signed [VALUE_W-1:0] value;

    modport source(output valid, output op, output value, input ready);
    modport sink(input valid, input op, input value, output ready);
endinterface

`default_nettype wire

FILE: rtl/smid_out_if.sv
// Result channel: one word per stored entry, in ascending order, or one is_empty word.
// Depends on smid_pkg for field widths.
`default_nettype none

interface smid_out_if
    import smid_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] entry_value;
    logic [POS_W-1:0]          position;
    logic [COUNT_W-1:0]        entry_count;
    logic                      is_last;
    logic                      is_empty;
    logic                      dropped_full;

    modport source(output valid, output entry_value, output position, output entry_count,
                   output is_last, output is_empty, output dropped_full, input ready);
    modport sink(input valid, input entry_value, input position, input entry_count,
                 input is_last, input is_empty, input dropped_full, output ready);
endinterface

`default_nettype wire

FILE: rtl/sorted_multiset_insert_delete.sv
// Sorted multiset insert/delete: top level with sequencer and shared compare.
// Depends on smid_pkg, smid_in_if, smid_out_if and smid_ram.
//
// Usage:
//   cmd carries one word per operation: op (insert or delete) and a signed value.
//   An insert places the value after any equal entries; a delete removes every
//   equal entry. Inserting into a full store leaves it unchanged and flags
//   dropped_full on every result word of that run.
//   After each command, rsp delivers the whole store in ascending order, one
//   word per entry, is_last on the final one; an empty store gives a single
//   word with is_empty set.
//   One command at a time: cmd.ready is high only while the block is idle.
//   Each accepted command is paced by one registered-read RAM port and one
//   compare per entry: an insert shifts larger entries up from the top, a
//   delete compacts survivors down; a refused insert goes straight to readout.
//   Readout then reads, loads and holds each result word (the empty word skips
//   the load), and cmd.ready returns the cycle after the last word is taken.
//   A stalled rsp simply holds the current word until taken.
//   Reset (rst_n low, asynchronous) empties the store; no clearing pass is
//   needed and cmd.ready rises right after reset.
`default_nettype none

module sorted_multiset_insert_delete
    import smid_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    smid_in_if.sink    cmd,
    smid_out_if.source rsp
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_INS_RD    = 8'b0000_0010,
        S_INS_CMP   = 8'b0000_0100,
        S_DEL_RD    = 8'b0000_1000,
        S_DEL_CMP   = 8'b0001_0000,
        S_EMIT_RD   = 8'b0010_0000,
        S_EMIT_LD   = 8'b0100_0000,
        S_EMIT_HOLD = 8'b1000_0000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          held_reg, held_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [CNT_W-1:0]          wr_reg, wr_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic                      dropped_reg, dropped_next;

    logic signed [VALUE_W-1:0] ent_reg, ent_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [COUNT_W-1:0]        cnt_reg, cnt_next;
    logic                      last_reg, last_next;
    logic                      empty_reg, empty_next;

    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [VALUE_W-1:0]        ram_wdata;
    logic [ADDR_W-1:0]         ram_raddr;
    logic [VALUE_W-1:0]        ram_rdata;

    logic [CNT_W-1:0]          idx_dec;
    logic [CNT_W-1:0]          idx_inc;
    logic                      cmp_gt;
    logic                      cmp_eq;

    smid_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign idx_dec   = idx_reg - 1'b1;
    assign idx_inc   = idx_reg + 1'b1;
    assign ram_raddr = (state_reg == S_INS_RD) ? idx_dec[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];

    // shared compare unit
    assign cmp_gt = $signed(ram_rdata) > value_reg;
    assign cmp_eq = $signed(ram_rdata) == value_reg;

    assign cmd.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = (state_reg == S_EMIT_HOLD);
    assign rsp.entry_value  = ent_reg;
    assign rsp.position     = pos_reg;
    assign rsp.entry_count  = cnt_reg;
    assign rsp.is_last      = last_reg;
    assign rsp.is_empty     = empty_reg;
    assign rsp.dropped_full = dropped_reg;

    always_comb
    begin
        state_next   = state_reg;
        held_next    = held_reg;
        idx_next     = idx_reg;
        wr_next      = wr_reg;
        value_next   = value_reg;
        dropped_next = dropped_reg;
        ent_next     = ent_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        empty_next   = empty_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg[ADDR_W-1:0];
        ram_wdata    = ram_rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    value_next   = cmd.value;
                    dropped_next = 1'b0;
                    wr_next      = '0;
                    if (cmd.op == OP_DELETE)
                    begin
                        idx_next   = '0;
                        state_next = S_DEL_RD;
                    end
                    else if (held_reg == CNT_W'(CAPACITY))
                    begin
                        dropped_next = 1'b1;
                        idx_next     = '0;
                        state_next   = S_EMIT_RD;
                    end
                    else
                    begin
                        idx_next   = held_reg;
                        state_next = S_INS_RD;
                    end
                end
            end
            S_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = value_reg;
                    held_next  = held_reg + 1'b1;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                ram_we = 1'b1;
                if (cmp_gt)
                begin
                    idx_next   = idx_dec;
                    state_next = S_INS_RD;
                end
                else
                begin
                    ram_wdata  = value_reg;
                    held_next  = held_reg + 1'b1;
                    idx_next   = '0;
                    state_next = S_EMIT_RD;
                end
            end
            S_DEL_RD:
            begin
                if (idx_reg == held_reg)
                begin
                    held_next  = wr_reg;
                    idx_next   = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    state_next = S_DEL_CMP;
                end
            end
            S_DEL_CMP:
            begin
                // compact survivors down; write index never passes read index
                if (!cmp_eq)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_reg[ADDR_W-1:0];
                    wr_next   = wr_reg + 1'b1;
                end
                idx_next   = idx_inc;
                state_next = S_DEL_RD;
            end
            S_EMIT_RD:
            begin
                if (held_reg == '0)
                begin
                    ent_next   = '0;
                    pos_next   = '0;
                    cnt_next   = '0;
                    last_next  = 1'b1;
                    empty_next = 1'b1;
                    state_next = S_EMIT_HOLD;
                end
                else
                begin
                    state_next = S_EMIT_LD;
                end
            end
            S_EMIT_LD:
            begin
                ent_next   = $signed(ram_rdata);
                pos_next   = pos_of(idx_reg);
                cnt_next   = count_of(held_reg);
                last_next  = (idx_inc == held_reg);
                empty_next = 1'b0;
                state_next = S_EMIT_HOLD;
            end
            S_EMIT_HOLD:
            begin
                if (rsp.ready)
                begin
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            held_reg    <= '0;
            idx_reg     <= '0;
            wr_reg      <= '0;
            dropped_reg <= 1'b0;
            last_reg    <= 1'b0;
            empty_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            idx_reg     <= idx_next;
            wr_reg      <= wr_next;
            dropped_reg <= dropped_next;
            last_reg    <= last_next;
            empty_reg   <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        ent_reg   <= ent_next;
        pos_reg   <= pos_next;
        cnt_reg   <= cnt_next;
    end

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(CAPACITY))
        else $error("held count exceeds capacity");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.ready && rsp.valid))
        else $error("command accepted while a result word is pending");

    a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEL_CMP) |-> (wr_reg <= idx_reg))
        else $error("compaction write overtook read");

    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.is_empty) |-> (rsp.is_last && rsp.entry_count == '0))
        else $error("empty word malformed");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.dropped_full) |-> (held_reg == CNT_W'(CAPACITY)))
        else $error("drop flagged with room in store");

endmodule

`default_nettype wire

FILE: rtl/smid_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module smid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for sorted_multiset_insert_delete: random insert/delete words
// are checked against a scoreboard that keeps its own sorted copy of the store.
// Depends on smid_pkg, smid_in_if, smid_out_if and the block's RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import smid_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 200;

    typedef struct {
        logic signed [VALUE_W-1:0] entry_value;
        logic [POS_W-1:0]          position;
        logic [COUNT_W-1:0]        entry_count;
        logic                      is_last;
        logic                      is_empty;
        logic                      dropped_full;
    } rsp_word_t;

    class multiset_scoreboard;
        logic signed [VALUE_W-1:0] contents[$];
        rsp_word_t                 expected_words[$];
        int unsigned               mismatches;

        function new();
            mismatches = 0;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        // Applies one command to the local store and queues the readout it causes.
        function void note_command(logic op, logic signed [VALUE_W-1:0] value);
            logic      dropped;
            int        pos;
            rsp_word_t w;
            dropped = 1'b0;
            if (op == OP_INSERT) begin
                if (contents.size() >= CAPACITY) begin
                    dropped = 1'b1;
                end
                else begin
                    pos = 0;
                    while (pos < contents.size() && contents[pos] <= value)
                        pos++;
                    contents.insert(pos, value);
                end
            end
            else begin
                for (int i = contents.size() - 1; i >= 0; i--)
                    if (contents[i] == value)
                        contents.delete(i);
            end
            if (contents.size() == 0) begin
                w.entry_value  = '0;
                w.position     = '0;
                w.entry_count  = '0;
                w.is_last      = 1'b1;
                w.is_empty     = 1'b1;
                w.dropped_full = 1'b0;
                expected_words.push_back(w);
            end
            else begin
                foreach (contents[k]) begin
                    w.entry_value  = contents[k];
                    w.position     = POS_W'(k);
                    w.entry_count  = COUNT_W'(contents.size());
                    w.is_last      = (k == contents.size() - 1);
                    w.is_empty     = 1'b0;
                    w.dropped_full = dropped;
                    expected_words.push_back(w);
                end
            end
        endfunction

        task check_field(string name, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        endtask

        task check_word(rsp_word_t got);
            rsp_word_t want;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word, value %h position %0d",
                                          got.entry_value, got.position));
                return;
            end
            want = expected_words.pop_front();
            check_field("entry_value", got.entry_value, want.entry_value);
            check_field("position", VALUE_W'(got.position), VALUE_W'(want.position));
            check_field("entry_count", VALUE_W'(got.entry_count), VALUE_W'(want.entry_count));
            check_field("is_last", VALUE_W'(got.is_last), VALUE_W'(want.is_last));
            check_field("is_empty", VALUE_W'(got.is_empty), VALUE_W'(want.is_empty));
            check_field("dropped_full", VALUE_W'(got.dropped_full), VALUE_W'(want.dropped_full));
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    smid_in_if  cmd_if ();
    smid_out_if rsp_if ();

    sorted_multiset_insert_delete dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    multiset_scoreboard        sb = new();
    int unsigned               cmd_idle_pct = 0;
    int unsigned               rsp_idle_pct = 0;
    int unsigned               idle_cycles  = 0;
    logic signed [VALUE_W-1:0] value_pool[8];
    logic signed [VALUE_W-1:0] extremes[4] = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin : rsp_monitor
        rsp_word_t got;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            got.entry_value  = rsp_if.entry_value;
            got.position     = rsp_if.position;
            got.entry_count  = rsp_if.entry_count;
            got.is_last      = rsp_if.is_last;
            got.is_empty     = rsp_if.is_empty;
            got.dropped_full = rsp_if.dropped_full;
            sb.check_word(got);
        end
        rsp_if.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_word(logic op, logic signed [VALUE_W-1:0] value);
        while ($urandom_range(0, 99) < cmd_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.op    <= op;
        cmd_if.value <= value;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        sb.note_command(op, value);
    endtask

    task automatic wait_for_readout();
        cmd_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_words.size() != 0);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return value_pool[$urandom_range(0, 7)];
        else if (sel == 6)
            return extremes[$urandom_range(0, 3)];
        else
            return $urandom;
    endfunction

    task automatic run_mixed(int count, int unsigned insert_pct, bit hit_deletes);
        logic                      op;
        logic signed [VALUE_W-1:0] value;
        repeat (count) begin
            if ($urandom_range(0, 24) == 0)
                wait_for_readout();
            op    = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE;
            value = pick_value();
            if (hit_deletes && op == OP_DELETE && sb.contents.size() != 0
                && $urandom_range(0, 99) < 70)
                value = sb.contents[$urandom_range(0, sb.contents.size() - 1)];
            send_word(op, value);
        end
    endtask

    initial
    begin
        cmd_if.valid = 1'b0;
        cmd_if.op    = OP_INSERT;
        cmd_if.value = '0;
        rsp_if.ready = 1'b0;
        cmd_idle_pct = 15;
        rsp_idle_pct = 67;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // delete on empty store, extremes, duplicates, absent delete, back to empty
        send_word(OP_DELETE, 5);
        send_word(OP_INSERT, 32'sh7fff_ffff);
        send_word(OP_INSERT, 32'sh8000_0000);
        send_word(OP_INSERT, 0);
        send_word(OP_INSERT, -1);
        send_word(OP_INSERT, 0);
        send_word(OP_INSERT, 0);
        send_word(OP_INSERT, 1);
        send_word(OP_DELETE, 0);
        send_word(OP_DELETE, 12345);
        send_word(OP_DELETE, 32'sh8000_0000);
        send_word(OP_DELETE, 32'sh7fff_ffff);
        send_word(OP_DELETE, -1);
        send_word(OP_DELETE, 1);
        send_word(OP_INSERT, 32'sh5555_5555);
        send_word(OP_INSERT, 32'shaaaa_aaaa);
        send_word(OP_DELETE, 32'sh5555_5555);
        send_word(OP_DELETE, 32'shaaaa_aaaa);
        wait_for_readout();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin cmd_idle_pct = 15; rsp_idle_pct = 67; end
                1: begin cmd_idle_pct = 67; rsp_idle_pct = 15; end
                default: begin cmd_idle_pct = 0; rsp_idle_pct = 0; end
            endcase
            foreach (value_pool[i])
                value_pool[i] = (i < 4) ? $urandom : int'($urandom_range(0, 15)) - 8;
            run_mixed(20, 65, 1'b0);
            // fill to capacity, then push past it
            while (sb.contents.size() < CAPACITY)
                send_word(OP_INSERT, pick_value());
            repeat (2) send_word(OP_INSERT, pick_value());
            run_mixed(15, 35, 1'b1);
            wait_for_readout();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
